// ----- design/rbs_pkg.sv -----
// Package for the ray-box slab test: widths, pipeline depth, register indexes and lane types.
package rbs_pkg;

	localparam int unsigned QW = 32;
	localparam int unsigned EPS_W = 17;
	localparam int unsigned DIFF_W = QW + 1;
	localparam int unsigned DIV_STAGES = QW + 1;
	localparam int unsigned DIV_LAT = DIV_STAGES + 2;
	localparam int unsigned NUM_AXES = 3;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EPS = 3'd6;

	localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

	// Per-axis slab interval found by one lane.
	typedef struct packed {
		logic signed [QW-1:0] lo;
		logic signed [QW-1:0] hi;
	} lane_res_t;

endpackage

// ----- design/rbs_if.sv -----
// Handshake interfaces for the ray input and the hit result.
interface ray_in_if;
	import rbs_pkg::*;
	logic valid;
	logic ready;
	logic signed [QW-1:0] origin_x;
	logic signed [QW-1:0] origin_y;
	logic signed [QW-1:0] origin_z;
	logic signed [QW-1:0] dir_x;
	logic signed [QW-1:0] dir_y;
	logic signed [QW-1:0] dir_z;
	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface hit_out_if;
	import rbs_pkg::*;
	logic valid;
	logic ready;
	logic is_hit;
	logic signed [QW-1:0] hit_time;
	modport source (output valid, is_hit, hit_time, input ready);
	modport sink (input valid, is_hit, hit_time, output ready);
endinterface

// ----- design/rbs_div.sv -----
// Pipelined signed divider: ((diff << 16) / d) truncated toward zero, saturated to 32 bits.
module rbs_div
	import rbs_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DIFF_W-1:0] diff,
	input  logic signed [QW-1:0]     d,
	output logic signed [QW-1:0]     q
);

	logic [DIFF_W-1:0] nmag;
	logic [QW-1:0]     dmag;
	logic              ovf;

	logic [QW-1:0]     rem_s  [0:DIV_STAGES];
	logic [DIFF_W-1:0] low_s  [0:DIV_STAGES];
	logic [QW-1:0]     dm_s   [0:DIV_STAGES];
	logic              neg_s  [0:DIV_STAGES];
	logic              ovf_s  [0:DIV_STAGES];

	logic [DIFF_W-1:0] quo;
	logic              big;
	logic signed [QW-1:0] q_s;

	// Magnitudes; a quotient of 2^33 or more is flagged up front.
	always_comb begin
		nmag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		dmag = d[QW-1] ? QW'(-d) : QW'(d);
		ovf  = {16'd0, nmag[DIFF_W-1:17]} >= dmag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {16'd0, nmag[DIFF_W-1:17]};
			low_s[0] <= {nmag[16:0], 16'd0};
			dm_s[0]  <= dmag;
			neg_s[0] <= diff[DIFF_W-1] ^ d[QW-1];
			ovf_s[0] <= ovf;
		end
	end

	// One quotient bit per stage, restoring division.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DIFF_W-1:0] sh;
		logic              ge;
		always_comb begin
			sh = {rem_s[k], low_s[k][DIFF_W-1]};
			ge = sh >= {1'b0, dm_s[k]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? QW'(sh - {1'b0, dm_s[k]}) : QW'(sh);
				low_s[k+1] <= {low_s[k][DIFF_W-2:0], ge};
				dm_s[k+1]  <= dm_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// Sign and saturation.
	always_comb begin
		quo = low_s[DIV_STAGES];
		if (neg_s[DIV_STAGES]) begin
			big = ovf_s[DIV_STAGES] || quo[QW] || (quo[QW-1] && (|quo[QW-2:0]));
		end else begin
			big = ovf_s[DIV_STAGES] || quo[QW] || quo[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (big) begin
				q_s <= neg_s[DIV_STAGES] ? Q_MIN : Q_MAX;
			end else begin
				q_s <= neg_s[DIV_STAGES] ? -$signed(quo[QW-1:0]) : $signed(quo[QW-1:0]);
			end
		end
	end

	assign q = q_s;

endmodule

// ----- design/rbs_lane.sv -----
// One axis lane: direction clamp, two slab divisions and their ordering.
module rbs_lane
	import rbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [QW-1:0] origin,
	input  logic signed [QW-1:0] dir,
	input  logic signed [QW-1:0] bmin,
	input  logic signed [QW-1:0] bmax,
	input  logic [EPS_W-1:0]     eps,
	output lane_res_t            res
);

	logic [QW:0]                 dmag;
	logic signed [QW-1:0]        dcl;
	logic signed [DIFF_W-1:0]    diff_a;
	logic signed [DIFF_W-1:0]    diff_b;
	logic signed [QW-1:0]        ta;
	logic signed [QW-1:0]        tb;

	// Replace a tiny direction by plus or minus epsilon.
	always_comb begin
		dmag = dir[QW-1] ? (QW+1)'(-$signed({dir[QW-1], dir})) : {1'b0, dir};
		if (dmag < (QW+1)'(eps)) begin
			dcl = (!dir[QW-1] && (|dir)) ? QW'(eps) : -$signed(QW'(eps));
		end else begin
			dcl = dir;
		end
		diff_a = DIFF_W'(bmin) - DIFF_W'(origin);
		diff_b = DIFF_W'(bmax) - DIFF_W'(origin);
	end

	rbs_div u_div_a (.clk(clk), .en(en), .diff(diff_a), .d(dcl), .q(ta));
	rbs_div u_div_b (.clk(clk), .en(en), .diff(diff_b), .d(dcl), .q(tb));

	// Order the two slab distances.
	always_comb begin
		res.lo = (ta < tb) ? ta : tb;
		res.hi = (ta < tb) ? tb : ta;
	end

endmodule

// ----- design/rbs_merge.sv -----
// Merge of the lane intervals into the hit flag and hit time.
module rbs_merge
	import rbs_pkg::*;
(
	input  lane_res_t            res [NUM_AXES],
	input  logic [EPS_W-1:0]     eps,
	output logic                 is_hit,
	output logic signed [QW-1:0] hit_time
);

	logic signed [QW-1:0] t0;
	logic signed [QW-1:0] t1;

	// Largest entry, smallest exit, then the miss and entry tests.
	always_comb begin
		t0 = res[0].lo;
		t1 = res[0].hi;
		for (int a = 1; a < NUM_AXES; a++) begin
			if (res[a].lo > t0) t0 = res[a].lo;
			if (res[a].hi < t1) t1 = res[a].hi;
		end
		is_hit   = !((t0 > t1) || t1[QW-1]);
		hit_time = (t0 < $signed({15'd0, eps})) ? t1 : t0;
	end

endmodule

// ----- design/ray_box_slab_intersect.sv -----
// Top level of the ray versus axis-aligned box slab test.
// One ray is accepted per clock and throughput is one ray per cycle while the output is
// not stalled. The pipeline depth is set by the six lane dividers, which resolve one quotient
// bit per pipeline stage over 33 stages, plus an input and an output register on each
// divider and the output word register. A stalled output holds the whole pipeline.
// Box corners and epsilon come from the write port and may change only when idle.
module ray_box_slab_intersect
	import rbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	ray_in_if.sink               ray,
	hit_out_if.source            hit,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [QW-1:0]        cfg_data
);

	logic signed [QW-1:0] bmin_q [NUM_AXES];
	logic signed [QW-1:0] bmax_q [NUM_AXES];
	logic [EPS_W-1:0]     eps_q;
	logic [EPS_W-1:0]     eps_e;
	logic                 en;
	logic [DIV_LAT-1:0]   vld_s;
	logic                 out_valid_q;
	logic                 is_hit_q;
	logic signed [QW-1:0] hit_time_q;
	lane_res_t            res [NUM_AXES];
	logic                 m_hit;
	logic signed [QW-1:0] m_time;
	logic signed [QW-1:0] org [NUM_AXES];
	logic signed [QW-1:0] dir [NUM_AXES];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				bmin_q[a] <= '0;
				bmax_q[a] <= 32'sd65536;
			end
			eps_q <= 17'd7;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_X: bmin_q[0] <= cfg_data;
				REG_MIN_Y: bmin_q[1] <= cfg_data;
				REG_MIN_Z: bmin_q[2] <= cfg_data;
				REG_MAX_X: bmax_q[0] <= cfg_data;
				REG_MAX_Y: bmax_q[1] <= cfg_data;
				REG_MAX_Z: bmax_q[2] <= cfg_data;
				REG_EPS:   eps_q <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	assign eps_e = (eps_q == '0) ? EPS_W'(1) : eps_q;

	// Pipeline advances unless a finished word waits on a stalled output.
	assign en = !out_valid_q || hit.ready;
	assign ray.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[DIV_LAT-2:0], ray.valid};
			out_valid_q <= vld_s[DIV_LAT-1];
		end
	end

	assign org[0] = ray.origin_x;
	assign org[1] = ray.origin_y;
	assign org[2] = ray.origin_z;
	assign dir[0] = ray.dir_x;
	assign dir[1] = ray.dir_y;
	assign dir[2] = ray.dir_z;

	// One lane per axis.
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		rbs_lane u_lane (
			.clk(clk), .en(en), .origin(org[a]), .dir(dir[a]),
			.bmin(bmin_q[a]), .bmax(bmax_q[a]), .eps(eps_e), .res(res[a])
		);
	end

	rbs_merge u_merge (.res(res), .eps(eps_e), .is_hit(m_hit), .hit_time(m_time));

	// Output word register.
	always_ff @(posedge clk) begin
		if (en) begin
			is_hit_q   <= m_hit;
			hit_time_q <= m_time;
		end
	end

	assign hit.valid    = out_valid_q;
	assign hit.is_hit   = is_hit_q;
	assign hit.hit_time = hit_time_q;

	// A hit always reports a nonnegative time.
	a_hit_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_hit_q) |-> !hit_time_q[QW-1])
		else $error("hit with negative time");

	// A waiting word is not dropped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit.ready) |=> out_valid_q)
		else $error("output word lost under stall");

	// No ray is taken while the pipeline is frozen.
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit.ready) |-> !ray.ready)
		else $error("input taken during stall");

	// A word in the last stage reaches the output when the pipeline moves.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s[DIV_LAT-1]) |=> out_valid_q)
		else $error("result lost at output stage");

endmodule
